// File: rtl/ps2md_pkg.sv
// Package for the PS/2 mouse packet decoder.
// Field widths, the packet struct between assembler and decoder, action codes.
// No dependencies.
package ps2md_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BTN_W    = 3;
    localparam int unsigned DX_W     = 9;
    localparam int unsigned DY_W     = 10;
    localparam int unsigned ACT_W    = 3;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 32;

    // header byte bit positions
    localparam int unsigned HDR_XSIGN = 4;
    localparam int unsigned HDR_YSIGN = 5;
    localparam int unsigned HDR_XOVER = 6;
    localparam int unsigned HDR_YOVER = 7;

    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2
    } byte_pos_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_PRESS   = 3'd1,
        ACT_RELEASE = 3'd2,
        ACT_MOVED   = 3'd3,
        ACT_DRAGGED = 3'd4
    } action_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] x_byte;
        logic [BYTE_W-1:0] y_byte;
    } packet_t;

    typedef struct packed {
        logic [BTN_W-1:0]       buttons;  // middle, right, left
        logic                   y_over;
        logic                   x_over;
        logic signed [DX_W-1:0] delta_x;
        logic signed [DY_W-1:0] delta_y;
        action_t                action;
    } result_t;

endpackage

// File: rtl/ps2md_assembler.sv
// Byte assembler: tracks position within a three-byte packet and registers
// each complete packet for the decoder. Depends on ps2md_pkg.
module ps2md_assembler (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_valid,
    output logic                          byte_ready,
    input  logic [ps2md_pkg::BYTE_W-1:0]  byte_data,
    output logic                          pkt_valid,
    input  logic                          pkt_ready,
    output ps2md_pkg::packet_t            pkt
);

    ps2md_pkg::byte_pos_t            pos_reg, pos_next;
    logic [ps2md_pkg::BYTE_W-1:0]    header_reg;
    logic [ps2md_pkg::BYTE_W-1:0]    x_reg;
    logic                            pkt_valid_reg, pkt_valid_next;
    ps2md_pkg::packet_t              pkt_reg;
    logic                            byte_acc;

    assign byte_ready = !pkt_valid_reg || pkt_ready;
    assign byte_acc   = byte_valid && byte_ready;

    always_comb begin
        pos_next = pos_reg;
        if (byte_acc) begin
            case (pos_reg)
                ps2md_pkg::POS_X: pos_next = ps2md_pkg::POS_Y;
                ps2md_pkg::POS_Y: pos_next = ps2md_pkg::POS_HEADER;
                default:          pos_next = ps2md_pkg::POS_X;
            endcase
        end
    end

    always_comb begin
        pkt_valid_next = pkt_valid_reg && !pkt_ready;
        if (byte_acc && pos_reg == ps2md_pkg::POS_Y) begin
            pkt_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= ps2md_pkg::POS_HEADER;
            pkt_valid_reg <= 1'b0;
            header_reg    <= '0;
            x_reg         <= '0;
        end else begin
            pos_reg       <= pos_next;
            pkt_valid_reg <= pkt_valid_next;
            if (byte_acc) begin
                case (pos_reg)
                    ps2md_pkg::POS_X: x_reg <= byte_data;
                    ps2md_pkg::POS_Y: ;
                    default:          header_reg <= byte_data;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_acc && pos_reg == ps2md_pkg::POS_Y) begin
            pkt_reg.header <= header_reg;
            pkt_reg.x_byte <= x_reg;
            pkt_reg.y_byte <= byte_data;
        end
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

endmodule

// File: rtl/ps2md_decoder.sv
// Packet decoder: movement decode, y negation and action classification
// against the previous buttons, into the result register. Depends on ps2md_pkg.
module ps2md_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pkt_valid,
    output logic                pkt_ready,
    input  ps2md_pkg::packet_t  pkt,
    output logic                res_valid,
    input  logic                res_ready,
    output ps2md_pkg::result_t  res
);

    logic [ps2md_pkg::BTN_W-1:0]        prior_reg;
    logic                               res_valid_reg, res_valid_next;
    ps2md_pkg::result_t                 res_reg, res_next;
    logic                               pkt_acc;
    logic [ps2md_pkg::BTN_W-1:0]        buttons;
    logic                               x_over, y_over;
    logic signed [ps2md_pkg::DX_W-1:0]  dx;
    logic signed [ps2md_pkg::DX_W-1:0]  dy_raw;
    logic signed [ps2md_pkg::DY_W-1:0]  dy;

    assign pkt_ready = !res_valid_reg || res_ready;
    assign pkt_acc   = pkt_valid && pkt_ready;

    always_comb begin
        buttons = pkt.header[ps2md_pkg::BTN_W-1:0];
        x_over  = pkt.header[ps2md_pkg::HDR_XOVER];
        y_over  = pkt.header[ps2md_pkg::HDR_YOVER];
        dx      = x_over ? '0 : {pkt.header[ps2md_pkg::HDR_XSIGN], pkt.x_byte};
        dy_raw  = y_over ? '0 : {pkt.header[ps2md_pkg::HDR_YSIGN], pkt.y_byte};
        dy      = -{dy_raw[ps2md_pkg::DX_W-1], dy_raw};

        res_next.buttons = buttons;
        res_next.x_over  = x_over;
        res_next.y_over  = y_over;
        res_next.delta_x = dx;
        res_next.delta_y = dy;
        if (buttons != prior_reg) begin
            res_next.action = (buttons != '0) ? ps2md_pkg::ACT_PRESS
                                              : ps2md_pkg::ACT_RELEASE;
        end else if (dx != '0 || dy_raw != '0) begin
            res_next.action = (buttons != '0) ? ps2md_pkg::ACT_DRAGGED
                                              : ps2md_pkg::ACT_MOVED;
        end else begin
            res_next.action = ps2md_pkg::ACT_NONE;
        end
    end

    always_comb begin
        res_valid_next = res_valid_reg && !res_ready;
        if (pkt_acc) begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            prior_reg     <= '0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (pkt_acc) begin
                prior_reg <= buttons;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pkt_acc) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/ps2_mouse_packet_decoder.sv
// The third byte beat loads the packet register, then the result register.
// Throughput: one byte beat per cycle absent m_tready stalls, set by the
// packet and result registers, each refilling in the cycle it is emptied.
// Reset: synchronous active-low aresetn; byte position returns to the header,
// the previous buttons clear to released and both registers empty.
module ps2_mouse_packet_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ps2md_pkg::S_DATA_W-1:0]  s_tdata,  // [7:0] rx_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] btn_left, [1] btn_right, [2] btn_middle, [3] x_over, [4] y_over,
    // [13:5] delta_x, [23:14] delta_y, [26:24] action_code, [31:27] zero
    output logic [ps2md_pkg::M_DATA_W-1:0]  m_tdata
);

    logic                pkt_valid, pkt_ready;
    ps2md_pkg::packet_t  pkt;
    ps2md_pkg::result_t  res;

    ps2md_assembler u_asm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid),
        .byte_ready (s_tready),
        .byte_data  (s_tdata[ps2md_pkg::BYTE_W-1:0]),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .pkt        (pkt)
    );

    ps2md_decoder u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {5'd0, res.action, res.delta_y, res.delta_x,
                      res.y_over, res.x_over,
                      res.buttons[2], res.buttons[1], res.buttons[0]};

    a_xover_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.x_over |-> res.delta_x == '0)
        else $error("delta_x nonzero with x overflow");

    a_yover_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.y_over |-> res.delta_y == '0)
        else $error("delta_y nonzero with y overflow");

    a_press_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res.action == ps2md_pkg::ACT_PRESS ||
                     res.action == ps2md_pkg::ACT_DRAGGED) |-> res.buttons != '0)
        else $error("press or drag reported with no button held");

    a_pkt_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt_valid && !pkt_ready |-> !s_tready)
        else $error("byte beat taken while packet register stalled");

endmodule
